// ===== design/icbr_pkg.sv =====
// Shared types and constants for the ICMP echo request builder.
package icbr_pkg;

  localparam int PACKET_BYTES_DEF = 64;
  localparam int MAX_PATTERN_DEF  = 16;
  localparam int PAYLOAD_START    = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_IDENT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = CFG_IDX_W'(3);

  localparam logic [7:0] ICMP_TYPE_ECHO = 8'd8;
  localparam logic [7:0] ICMP_CODE_ZERO = 8'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_FOLD1,
    S_FOLD2,
    S_OUT
  } state_t;

  // checksum unit control
  typedef struct packed {
    logic clr;
    logic add;
    logic fold;
  } cs_ctl_t;

endpackage

// ===== design/icbr_byte_gen.sv =====
// Message byte generator: byte at a position, checksum field taken as zero.
module icbr_byte_gen #(
  parameter int PW = 6
) (
  input  logic [PW-1:0] pos,
  input  logic [3:0]    pidx,
  input  logic          incr_mode,
  input  logic [15:0]   identifier,
  input  logic [127:0]  pattern,
  input  logic [15:0]   seq,
  input  logic [62:0]   sec,
  input  logic [19:0]   usec,
  output logic [7:0]    byte_out
);
  import icbr_pkg::*;

  logic [63:0]   sec64;
  logic [63:0]   usec64;
  logic [PW+7:0] off;

  assign sec64  = {1'b0, sec};
  assign usec64 = {44'd0, usec};
  assign off    = {8'd0, pos} - (PW+8)'(PAYLOAD_START);

  always_comb begin
    byte_out = 8'd0;
    if (pos < PW'(8)) begin
      unique case (pos[2:0])
        3'd0: byte_out = ICMP_TYPE_ECHO;
        3'd1: byte_out = ICMP_CODE_ZERO;
        3'd2: byte_out = 8'd0;
        3'd3: byte_out = 8'd0;
        3'd4: byte_out = identifier[15:8];
        3'd5: byte_out = identifier[7:0];
        3'd6: byte_out = seq[15:8];
        3'd7: byte_out = seq[7:0];
        default: byte_out = 8'd0;
      endcase
    end else if (pos < PW'(16)) begin
      byte_out = sec64[pos[2:0]*8 +: 8];
    end else if (pos < PW'(PAYLOAD_START)) begin
      byte_out = usec64[pos[2:0]*8 +: 8];
    end else if (incr_mode) begin
      byte_out = off[7:0];
    end else begin
      byte_out = pattern[pidx*8 +: 8];
    end
  end

endmodule

// ===== design/icbr_csum.sv =====
// Ones'-complement checksum accumulator around one shared 32-bit adder.
module icbr_csum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  icbr_pkg::cs_ctl_t    ctl,
  input  logic [15:0]          word,
  output logic [15:0]          csum
);
  import icbr_pkg::*;

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] op_a;
  logic [31:0] op_b;

  // fold: low half + high half; add: acc + word
  assign op_a = ctl.fold ? {16'd0, acc_r[15:0]}  : acc_r;
  assign op_b = ctl.fold ? {16'd0, acc_r[31:16]} : {16'd0, word};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = 32'd0;
    end else if (ctl.add || ctl.fold) begin
      acc_nxt = op_a + op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign csum = ~acc_r[15:0];

endmodule

// ===== design/icmp_echo_request_builder_core.sv =====
// ICMP echo request builder: top level with sequencer, config and output register.
// Flow: the idle state takes the input beat, then the word-summing pass runs through the
//   single checksum adder, then two folds, then one byte per cycle goes out while the
//   output is not stalled. Input is stalled from acceptance until the last byte is loaded.
// Reset (rst_n low, synchronous): sequencer idle, output empty, all config registers 0.
module icmp_echo_request_builder_core #(
  parameter int PACKET_BYTES = icbr_pkg::PACKET_BYTES_DEF,
  parameter int MAX_PATTERN  = icbr_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_sequence_number,
  input  logic [62:0]                     in_time_seconds,
  input  logic [19:0]                     in_time_microseconds,
  // byte output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_packet_byte,
  output logic                            out_final_byte,
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [icbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import icbr_pkg::*;

  localparam int PW        = $clog2(PACKET_BYTES);
  localparam int LAST_WORD = ((PACKET_BYTES - 1) / 2) * 2;
  localparam bit ODD_LEN   = (PACKET_BYTES % 2) == 1;

  // advance pattern index, wrapping at the effective pattern length
  function automatic logic [3:0] pat_next(input logic [3:0] p, input logic [4:0] len);
    logic [4:0] q;
    q = {1'b0, p} + 5'd1;
    return (q >= len) ? 4'd0 : q[3:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic [15:0] ident_r;
  logic [4:0]  pat_len_r;
  logic [63:0] pat_lo_r;
  logic [63:0] pat_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r   <= 16'd0;
      pat_len_r <= 5'd0;
      pat_lo_r  <= 64'd0;
      pat_hi_r  <= 64'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IDENT:   ident_r   <= cfg_data[15:0];
        REG_PAT_LEN: pat_len_r <= cfg_data[4:0];
        REG_PAT_LO:  pat_lo_r  <= cfg_data;
        REG_PAT_HI:  pat_hi_r  <= cfg_data;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  // lengths above the pattern store saturate; zero selects counting bytes
  logic [4:0] plen_eff;
  logic       incr_mode;
  assign plen_eff  = (pat_len_r > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : pat_len_r;
  assign incr_mode = (plen_eff == 5'd0);

  // ---------------- sequencer ----------------
  state_t        state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [3:0]    pidx_r, pidx_nxt;
  logic [15:0]   seq_r;
  logic [62:0]   sec_r;
  logic [19:0]   usec_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_final_r;

  logic          in_beat;
  logic          load_out;
  logic          pos_payload;
  logic [3:0]    pidx_lo;
  logic [PW-1:0] pos_lo;
  logic [7:0]    gen_hi;
  logic [7:0]    gen_lo;
  logic [15:0]   sum_word;
  logic [15:0]   csum;
  logic [7:0]    out_byte_sel;
  cs_ctl_t       cs_ctl;

  assign in_stall    = (state_r != S_IDLE);
  assign in_beat     = in_valid && !in_stall;
  // output register free or draining this cycle
  assign load_out    = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign pos_payload = (pos_r >= PW'(PAYLOAD_START));

  // low byte of a summing word sits at the odd neighbour
  assign pos_lo  = pos_r | PW'(1);
  assign pidx_lo = pat_next(pidx_r, plen_eff);

  icbr_byte_gen #(.PW(PW)) u_gen_hi (
    .pos        (pos_r),
    .pidx       (pidx_r),
    .incr_mode  (incr_mode),
    .identifier (ident_r),
    .pattern    ({pat_hi_r, pat_lo_r}),
    .seq        (seq_r),
    .sec        (sec_r),
    .usec       (usec_r),
    .byte_out   (gen_hi)
  );

  icbr_byte_gen #(.PW(PW)) u_gen_lo (
    .pos        (pos_lo),
    .pidx       (pidx_lo),
    .incr_mode  (incr_mode),
    .identifier (ident_r),
    .pattern    ({pat_hi_r, pat_lo_r}),
    .seq        (seq_r),
    .sec        (sec_r),
    .usec       (usec_r),
    .byte_out   (gen_lo)
  );

  // odd-length message: trailing byte pairs with a zero low half
  assign sum_word = (ODD_LEN && (pos_r == PW'(LAST_WORD))) ? {gen_hi, 8'd0}
                                                           : {gen_hi, gen_lo};

  icbr_csum u_csum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cs_ctl),
    .word  (sum_word),
    .csum  (csum)
  );

  // checksum field replaces bytes 2 and 3 on the way out
  always_comb begin
    if (pos_r == PW'(2)) begin
      out_byte_sel = csum[15:8];
    end else if (pos_r == PW'(3)) begin
      out_byte_sel = csum[7:0];
    end else begin
      out_byte_sel = gen_hi;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    pidx_nxt      = pidx_r;
    cs_ctl        = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          state_nxt  = S_SUM;
          pos_nxt    = '0;
          pidx_nxt   = 4'd0;
          cs_ctl.clr = 1'b1;
        end
      end
      S_SUM: begin
        // two bytes per cycle into the accumulator
        cs_ctl.add = 1'b1;
        if (pos_payload) begin
          pidx_nxt = pat_next(pidx_lo, plen_eff);
        end
        if (pos_r == PW'(LAST_WORD)) begin
          state_nxt = S_FOLD1;
        end else begin
          pos_nxt = pos_r + PW'(2);
        end
      end
      S_FOLD1: begin
        cs_ctl.fold = 1'b1;
        state_nxt   = S_FOLD2;
      end
      S_FOLD2: begin
        cs_ctl.fold = 1'b1;
        state_nxt   = S_OUT;
        pos_nxt     = '0;
        pidx_nxt    = 4'd0;
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (pos_payload) begin
            pidx_nxt = pidx_lo;
          end
          if (pos_r == PW'(PACKET_BYTES - 1)) begin
            state_nxt = S_IDLE;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      pidx_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pidx_r      <= pidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture and output payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      seq_r  <= in_sequence_number;
      sec_r  <= in_time_seconds;
      usec_r <= in_time_microseconds;
    end
    if (load_out) begin
      out_byte_r  <= out_byte_sel;
      out_final_r <= (pos_r == PW'(PACKET_BYTES - 1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packet_byte = out_byte_r;
  assign out_final_byte  = out_final_r;

endmodule

// ===== dv/icmp_echo_checker.sv =====
// Scoreboard for the echo request builder: snoops config, predicts packets, checks beats.
`timescale 1ns / 100ps
module icmp_echo_checker
  import icbr_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int MAX_PATTERN  = MAX_PATTERN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [15:0]           in_sequence_number,
  input  logic [62:0]           in_time_seconds,
  input  logic [19:0]           in_time_microseconds,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_packet_byte,
  input  logic                  out_final_byte,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatch_count,
  output int unsigned           bytes_pending
);

  localparam int REPORT_LIMIT = 10;
  localparam int SECONDS_AT   = 8;
  localparam int MICROS_AT    = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packet_beat_t;

  // shadow copy of the block's registers
  logic [15:0] echo_id;
  logic [4:0]  pat_len;
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;

  packet_beat_t expected_beats[$];
  int unsigned  fail_total;
  int unsigned  beat_index;

  // message byte with the checksum field still zero
  function automatic logic [7:0] message_byte(input int pos, input logic [15:0] seq,
                                              input logic [62:0] sec, input logic [19:0] usec);
    int           plen;
    int           off;
    logic [127:0] pattern;
    logic [63:0]  sec64;
    logic [63:0]  usec64;
    sec64   = {1'b0, sec};
    usec64  = {44'd0, usec};
    pattern = {pat_hi, pat_lo};
    case (pos)
      0:       return ICMP_TYPE_ECHO;
      1:       return ICMP_CODE_ZERO;
      2, 3:    return 8'h00;
      4:       return echo_id[15:8];
      5:       return echo_id[7:0];
      6:       return seq[15:8];
      7:       return seq[7:0];
      default: ;
    endcase
    if (pos < MICROS_AT) return sec64[8*(pos-SECONDS_AT) +: 8];
    if (pos < PAYLOAD_START) return usec64[8*(pos-MICROS_AT) +: 8];
    off  = pos - PAYLOAD_START;
    plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    if (plen == 0) return 8'(off);
    return pattern[8*((off % plen) & 15) +: 8];
  endfunction

  // builds the whole request and queues one beat per byte
  function automatic void predict_echo_request(input logic [15:0] seq, input logic [62:0] sec,
                                               input logic [19:0] usec);
    logic [7:0]   msg [PACKET_BYTES];
    logic [31:0]  word_sum;
    logic [31:0]  folded;
    logic [15:0]  csum;
    packet_beat_t beat;
    for (int p = 0; p < PACKET_BYTES; p++) msg[p] = message_byte(p, seq, sec, usec);
    word_sum = '0;
    // odd length: trailing byte is the high half of a word padded with zero
    for (int p = 0; p < PACKET_BYTES; p += 2)
      word_sum += {16'd0, msg[p], ((p + 1 < PACKET_BYTES) ? msg[p+1] : 8'h00)};
    folded = {16'd0, word_sum[31:16]} + {16'd0, word_sum[15:0]};
    folded = {16'd0, folded[31:16]} + {16'd0, folded[15:0]};
    csum   = ~folded[15:0];
    msg[2] = csum[15:8];
    msg[3] = csum[7:0];
    for (int p = 0; p < PACKET_BYTES; p++) begin
      beat.data = msg[p];
      beat.last = (p == PACKET_BYTES - 1);
      expected_beats.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    packet_beat_t want;
    if (!rst_n) begin
      echo_id    = '0;
      pat_len    = '0;
      pat_lo     = '0;
      pat_hi     = '0;
      fail_total = 0;
      beat_index = 0;
      expected_beats.delete();
      mismatch_count <= 0;
      bytes_pending  <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IDENT:   echo_id = cfg_data[15:0];
          REG_PAT_LEN: pat_len = cfg_data[4:0];
          REG_PAT_LO:  pat_lo  = cfg_data;
          REG_PAT_HI:  pat_hi  = cfg_data;
          default:     ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: unexpected beat byte=%02h final=%0b", $time,
                     out_packet_byte, out_final_byte);
        end else begin
          want = expected_beats.pop_front();
          if (out_packet_byte !== want.data || out_final_byte !== want.last) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("%0t: byte %0d: packet_byte %02h exp %02h, final_byte %0b exp %0b",
                       $time, beat_index, out_packet_byte, want.data,
                       out_final_byte, want.last);
          end
          beat_index = want.last ? 0 : beat_index + 1;
        end
      end
      if (in_valid && !in_stall)
        predict_echo_request(in_sequence_number, in_time_seconds, in_time_microseconds);
      mismatch_count <= fail_total;
      bytes_pending  <= expected_beats.size();
    end
  end

endmodule

// ===== dv/icmp_echo_request_builder_core_tb.sv =====
// Testbench top for the echo request builder: stimulus, config, back-pressure and verdict.
`timescale 1ns / 100ps
module icmp_echo_request_builder_core_tb;
  import icbr_pkg::*;

  localparam int CLK_HALF_NS     = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int MAX_IDLE        = 8;
  localparam int LONG_HOLD       = 600;
  localparam int TOTAL_REQUESTS  = 450;
  localparam int REG_COUNT       = 4;
  // settle time before the verdict, for any stray beat
  localparam int DRAIN_CYCLES    = PACKET_BYTES_DEF / 2 + 16;
  // upper bound on the run length for the watchdog
  localparam int CYCLE_LIMIT     = 1_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_sequence_number;
  logic [62:0]           in_time_seconds;
  logic [19:0]           in_time_microseconds;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_packet_byte;
  logic                  out_final_byte;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned bytes_pending;
  int unsigned cycle_count;
  int unsigned sent_count;

  // idling profile, set per phase by the stimulus
  int unsigned tx_max;
  int unsigned rx_max;
  bit          rx_hold_req;

  icmp_echo_request_builder_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sequence_number   (in_sequence_number),
    .in_time_seconds      (in_time_seconds),
    .in_time_microseconds (in_time_microseconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_packet_byte      (out_packet_byte),
    .out_final_byte       (out_final_byte),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  icmp_echo_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sequence_number   (in_sequence_number),
    .in_time_seconds      (in_time_seconds),
    .in_time_microseconds (in_time_microseconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_packet_byte      (out_packet_byte),
    .out_final_byte       (out_final_byte),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .mismatch_count       (mismatch_count),
    .bytes_pending        (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // none, full-range or a random ceiling on per-beat idling
  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return MAX_IDLE;
      default: return $urandom_range(1, MAX_IDLE);
    endcase
  endfunction

  // One register write per edge; the caller lowers the write enable.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes all four registers with junk in the unused upper data bits, plus one
  // write to an unmapped index that the block must ignore.
  task automatic load_config(input logic [15:0] ident, input logic [4:0] plen,
                             input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] noise;
    noise = rand64();
    write_reg(REG_IDENT, {noise[63:16], ident});
    write_reg(REG_PAT_LEN, {noise[63:5], plen});
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)), rand64());
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one request after a random gap and returns on the edge that takes it.
  // Valid is left high so a back-to-back request keeps it up without a dip.
  task automatic send_request(input logic [15:0] seq, input logic [62:0] sec,
                              input logic [19:0] usec);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_sequence_number   <= seq;
    in_time_seconds      <= sec;
    in_time_microseconds <= usec;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent_count++;
  endtask

  // Sender pauses until every expected beat has been seen.
  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
  endtask

  // Receiver: draws a stall before each beat, and on request holds off for a
  // long stretch so the block backs up and stalls its input.
  initial begin
    int unsigned wait_cycles;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      wait_cycles = $urandom_range(0, rx_max);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Stimulus
  initial begin
    logic [63:0]  r;
    logic [15:0]  seq;
    logic [62:0]  sec;
    logic [19:0]  usec;
    logic [4:0]   plen;
    int unsigned  phase_len;
    int unsigned  phase_no;

    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_sequence_number   <= '0;
    in_time_seconds      <= '0;
    in_time_microseconds <= '0;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    tx_max      = 0;
    rx_max      = 0;
    rx_hold_req = 1'b0;
    sent_count  = 0;
    phase_no    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // Reset config: identifier 0, incrementing payload.
    send_request(16'h0000, '0, 20'd0);
    send_request(16'hFFFF, '1, 20'd999_999);
    // microseconds past a second go out as given
    tx_max = MAX_IDLE;
    rx_max = MAX_IDLE;
    send_request(16'h1234, 63'd1, 20'd1_000_000);
    send_request(16'h8000, 63'h4000_0000_0000_0000, 20'hFFFFF);
    drain_requests();

    // All-ones everything: heaviest carry folding in the checksum.
    load_config(16'hFFFF, 5'(MAX_PATTERN_DEF), '1, '1);
    tx_max = 0;
    rx_max = 0;
    send_request(16'hFFFF, '1, 20'hFFFFF);
    send_request(16'h0000, '0, 20'd0);
    drain_requests();

    // Pattern length above the maximum saturates; ramp pattern makes order visible.
    load_config(16'h0001, 5'd31, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908);
    send_request(16'h0102, 63'h0123_4567_89AB_CDEF, 20'h5A5A5);
    drain_requests();
    load_config(16'h8000, 5'(MAX_PATTERN_DEF + 1), rand64(), rand64());
    send_request(16'($urandom), 63'(rand64()), 20'($urandom_range(0, 999_999)));
    drain_requests();

    // Short patterns: single byte, odd length, one under the maximum.
    load_config(16'hA55A, 5'd1, rand64(), rand64());
    send_request(16'($urandom), 63'(rand64()), 20'($urandom_range(0, 999_999)));
    send_request(16'($urandom), 63'(rand64()), 20'($urandom_range(0, 999_999)));
    drain_requests();
    load_config(16'h5AA5, 5'd3, rand64(), rand64());
    send_request(16'($urandom), 63'(rand64()), 20'($urandom_range(0, 999_999)));
    send_request(16'($urandom), 63'(rand64()), 20'($urandom_range(0, 999_999)));
    drain_requests();
    load_config(16'($urandom), 5'(MAX_PATTERN_DEF - 1), rand64(), rand64());
    send_request(16'($urandom), 63'(rand64()), 20'($urandom_range(0, 999_999)));
    drain_requests();

    // Back to incrementing bytes with the pattern registers loaded.
    load_config(16'h0000, 5'd0, '1, '1);
    send_request(16'($urandom), 63'(rand64()), 20'($urandom_range(0, 999_999)));
    drain_requests();

    // --- random phases ---
    while (sent_count < TOTAL_REQUESTS) begin
      case ($urandom_range(0, 5))
        0:       plen = 5'd0;
        1:       plen = 5'(MAX_PATTERN_DEF);
        2:       plen = 5'($urandom_range(MAX_PATTERN_DEF + 1, 31));
        default: plen = 5'($urandom_range(1, MAX_PATTERN_DEF - 1));
      endcase
      load_config(16'($urandom), plen, rand64(), rand64());
      tx_max    = pick_idle();
      rx_max    = pick_idle();
      phase_len = $urandom_range(8, 40);
      // one phase with the receiver going quiet while the sender keeps offering
      if (phase_no == 1) begin
        rx_hold_req = 1'b1;
        tx_max      = 0;
      end
      repeat (phase_len) begin
        r   = rand64();
        seq = 16'($urandom);
        sec = r[62:0];
        case ($urandom_range(0, 9))
          0:       sec = '0;
          1:       sec = '1;
          2:       sec = 63'($urandom);
          default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
          usec = 20'($urandom_range(1_000_000, 20'hFFFFF));
        else
          usec = 20'($urandom_range(0, 999_999));
        send_request(seq, sec, usec);
      end
      drain_requests();
      phase_no++;
    end

    // Let any stray beat show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && bytes_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
